FILE: rtl/core/wmss_pkg.sv
package wmss_pkg;

  // item opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BASE = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // base codes
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MOTIF_LENGTH      = 3'd0;
  localparam logic [2:0] REG_SCORE_CUTOFF      = 3'd1;
  localparam logic [2:0] REG_REPORT_COUNT      = 3'd2;
  localparam logic [2:0] REG_SCAN_REVERSE      = 3'd3;
  localparam logic [2:0] REG_RETURN_ALL_SCORES = 3'd4;

  localparam int SEEN_W = 21;

  localparam logic signed [23:0] SCORE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SCORE_MIN = 24'sh800000;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         weight_row;
    logic [1:0]         weight_base;
    logic signed [15:0] weight_value;
    logic [2:0]         base_code;
  } item_t;

  typedef struct packed {
    logic signed [23:0] hit_score;
    logic [19:0]        hit_position;
    logic               hit_strand;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic signed [23:0] score;
    logic [19:0]        position;
    logic               strand;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } list_ctrl_t;

endpackage

FILE: rtl/core/wmss_cell.sv
module wmss_cell #(
  parameter int WEIGHT_BITS = 16,
  parameter int SUM_BITS    = 22
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [1:0]                 wr_base,
  input  logic signed [WEIGHT_BITS-1:0] wr_value,
  input  wmss_pkg::cell_ctrl_t       ctrl,
  input  logic                       active,
  input  logic [2:0]                 fwd_load,
  input  logic [2:0]                 rev_load,
  input  logic [2:0]                 fwd_shift_in,
  output logic [2:0]                 fwd_base,
  input  logic signed [SUM_BITS-1:0] fwd_sum_in,
  input  logic signed [SUM_BITS-1:0] rev_sum_in,
  output logic signed [SUM_BITS-1:0] fwd_sum,
  output logic signed [SUM_BITS-1:0] rev_sum
);

  logic signed [WEIGHT_BITS-1:0] w_a, w_c, w_g, w_t;
  logic signed [WEIGHT_BITS-1:0] col_min, min_ac, min_gt, min_next;
  logic signed [WEIGHT_BITS-1:0] fwd_term, rev_term;
  logic [2:0] rev_base;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_base)
        2'd0:    w_a <= wr_value;
        2'd1:    w_c <= wr_value;
        2'd2:    w_g <= wr_value;
        default: w_t <= wr_value;
      endcase
    end
  end

  // column minimum for the N code, registered behind the weights
  assign min_ac   = (w_a < w_c) ? w_a : w_c;
  assign min_gt   = (w_g < w_t) ? w_g : w_t;
  assign min_next = (min_ac < min_gt) ? min_ac : min_gt;

  always_ff @(posedge clk) begin
    col_min <= min_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      fwd_base <= fwd_load;
      rev_base <= rev_load;
    end else if (ctrl.shift) begin
      fwd_base <= fwd_shift_in;
    end
  end

  always_comb begin
    case (fwd_base)
      wmss_pkg::BASE_A: fwd_term = w_a;
      wmss_pkg::BASE_C: fwd_term = w_c;
      wmss_pkg::BASE_G: fwd_term = w_g;
      wmss_pkg::BASE_T: fwd_term = w_t;
      wmss_pkg::BASE_N: fwd_term = col_min;
      default:          fwd_term = '0;
    endcase
  end

  // reverse strand reads the complement base
  always_comb begin
    case (rev_base)
      wmss_pkg::BASE_A: rev_term = w_t;
      wmss_pkg::BASE_C: rev_term = w_g;
      wmss_pkg::BASE_G: rev_term = w_c;
      wmss_pkg::BASE_T: rev_term = w_a;
      wmss_pkg::BASE_N: rev_term = col_min;
      default:          rev_term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    fwd_sum <= fwd_sum_in + (active ? SUM_BITS'(fwd_term) : SUM_BITS'(0));
    rev_sum <= rev_sum_in + (active ? SUM_BITS'(rev_term) : SUM_BITS'(0));
  end

endmodule

FILE: rtl/core/wmss_list.sv
module wmss_list #(
  parameter int TOP_N = 16,
  parameter int CAP_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wmss_pkg::list_ctrl_t ctrl,
  input  logic [CAP_W-1:0]     cap,
  input  wmss_pkg::entry_t     new_entry,
  output wmss_pkg::entry_t     head,
  output logic                 head_filled,
  output logic                 next_filled
);

  wmss_pkg::entry_t ent [TOP_N];
  logic [TOP_N-1:0] filled;
  logic [TOP_N-1:0] ranks;

  // higher score, then forward strand, then lower position
  function automatic logic outranks(wmss_pkg::entry_t a, wmss_pkg::entry_t b);
    logic res;
    if (a.score != b.score) begin
      res = a.score > b.score;
    end else if (a.strand != b.strand) begin
      res = a.strand < b.strand;
    end else begin
      res = a.position < b.position;
    end
    return res;
  endfunction

  for (genvar k = 0; k < TOP_N; k++) begin : g_slot
    wmss_pkg::entry_t prev_e, next_e;
    logic prev_r, prev_f, next_f;

    assign ranks[k] = (CAP_W'(k) < cap) && (!filled[k] || outranks(new_entry, ent[k]));

    if (k == 0) begin : g_first
      assign prev_e = new_entry;
      assign prev_r = 1'b0;
      assign prev_f = 1'b0;
    end else begin : g_mid
      assign prev_e = ent[k-1];
      assign prev_r = ranks[k-1];
      assign prev_f = filled[k-1];
    end

    if (k == TOP_N - 1) begin : g_last
      assign next_e = ent[k];
      assign next_f = 1'b0;
    end else begin : g_inner
      assign next_e = ent[k+1];
      assign next_f = filled[k+1];
    end

    always_ff @(posedge clk) begin
      if (rst || ctrl.clear) begin
        filled[k] <= 1'b0;
      end else if (ctrl.pop) begin
        filled[k] <= next_f;
      end else if (ctrl.insert && ranks[k]) begin
        filled[k] <= prev_r ? prev_f : 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.pop) begin
        ent[k] <= next_e;
      end else if (ctrl.insert && ranks[k]) begin
        ent[k] <= prev_r ? prev_e : new_entry;
      end
    end
  end

  assign head        = ent[0];
  assign head_filled = filled[0];

  if (TOP_N > 1) begin : g_next
    assign next_filled = filled[1];
  end else begin : g_single
    assign next_filled = 1'b0;
  end

endmodule

FILE: rtl/core/weight_matrix_sequence_scan.sv
// Position weight matrix scanner. Weights (signed Q8.8, one per item with op load) go
// into a row of MAX_LEN column cells; sequence bases then come one per item, and each
// full window of motif_length bases is scored on the forward strand and, with
// scan_reverse, on the reverse complement, as saturated signed Q16.8 sums. Results
// either list every forward score, stream every hit at or above score_cutoff (forward
// before reverse within a window), or build a best-hit list of up to report_count entries
// (at most TOP_N) that the end op reports in rank order before clearing the sequence
// state. A weight load, an unused op and a base that does not yet complete a window
// leave the input free for the next item. A base that completes a window holds the
// input while the window is copied into the cells, shifted MAX_LEN - L places to line
// up with its columns, with L the clamped motif_length, and while the partial sums
// ripple through all MAX_LEN cells, one cell per cycle, and the result is listed or
// streamed. The end op holds the input while the list reports its hits and the
// sequence state is cleared, and any wait for the receiver holds it too. A result
// waits in an output register, and the block takes the next item while it waits.
module weight_matrix_sequence_scan #(
  parameter int MAX_LEN       = 32,
  parameter int TOP_N         = 16,
  parameter int WEIGHT_BITS   = 16,
  parameter int POSITION_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  wmss_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output wmss_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int CAP_W    = $clog2(TOP_N + 1);
  localparam int SUM_BITS = WEIGHT_BITS + $clog2(MAX_LEN) + 1;
  localparam int CMP_W    = (SUM_BITS > 25) ? SUM_BITS : 25;
  localparam logic [32:0] POS_MAX = (33'd1 << POSITION_BITS) - 33'd1;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_ALIGN  = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_EMIT_F = 4'd5;
  localparam logic [3:0] S_EMIT_R = 4'd6;
  localparam logic [3:0] S_INS_R  = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_CLEAR  = 4'd9;

  // configuration registers
  logic [5:0]         motif_length;
  logic signed [23:0] score_cutoff;
  logic [4:0]         report_count;
  logic               scan_reverse;
  logic               return_all_scores;

  logic [3:0] state, state_next;
  logic [LEN_W-1:0] count, count_next;
  logic [CAP_W-1:0] drain, drain_next;
  logic [wmss_pkg::SEEN_W-1:0] seen, seen_inc;

  logic [2:0] hist [MAX_LEN];

  logic item_acc, cfg_wr, base_acc, seq_clear, out_free, emit;
  logic [LEN_W-1:0] eff_len;
  logic [CAP_W-1:0] cap;
  wmss_pkg::result_t res_next;
  wmss_pkg::cell_ctrl_t cell_ctrl;
  wmss_pkg::list_ctrl_t list_ctrl;

  logic [MAX_LEN-1:0] wr_en, act;
  logic [2:0] fb [MAX_LEN];
  logic signed [SUM_BITS-1:0] fwd_sum [MAX_LEN];
  logic signed [SUM_BITS-1:0] rev_sum [MAX_LEN];
  logic signed [WEIGHT_BITS-1:0] wr_value;

  logic signed [CMP_W-1:0] fwd_wide, rev_wide;
  logic signed [23:0] fwd_score, rev_score;
  logic fwd_hit, rev_hit;
  logic [wmss_pkg::SEEN_W-1:0] pos_full;
  logic [32:0] pos_sat;
  logic [19:0] pos;

  wmss_pkg::entry_t list_new, list_head;
  logic head_filled, next_filled;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_length      <= 6'd1;
      score_cutoff      <= '0;
      report_count      <= '0;
      scan_reverse      <= 1'b0;
      return_all_scores <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        wmss_pkg::REG_MOTIF_LENGTH:      motif_length      <= pwdata[5:0];
        wmss_pkg::REG_SCORE_CUTOFF:      score_cutoff      <= pwdata[23:0];
        wmss_pkg::REG_REPORT_COUNT:      report_count      <= pwdata[4:0];
        wmss_pkg::REG_SCAN_REVERSE:      scan_reverse      <= pwdata[0];
        wmss_pkg::REG_RETURN_ALL_SCORES: return_all_scores <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      wmss_pkg::REG_MOTIF_LENGTH:      prdata = 32'(motif_length);
      wmss_pkg::REG_SCORE_CUTOFF:      prdata = 32'(score_cutoff);
      wmss_pkg::REG_REPORT_COUNT:      prdata = 32'(report_count);
      wmss_pkg::REG_SCAN_REVERSE:      prdata = 32'(scan_reverse);
      wmss_pkg::REG_RETURN_ALL_SCORES: prdata = 32'(return_all_scores);
      default:                         prdata = '0;
    endcase
  end

  // effective window length and list size, clamped to what the hardware holds
  always_comb begin
    if (motif_length == 6'd0) begin
      eff_len = LEN_W'(1);
    end else if (32'(motif_length) > MAX_LEN) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = LEN_W'(motif_length);
    end
    if (32'(report_count) > TOP_N) begin
      cap = CAP_W'(TOP_N);
    end else begin
      cap = CAP_W'(report_count);
    end
  end

  // ---------------------------------------------------------------- base history
  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign base_acc   = item_acc && (item.op == wmss_pkg::OP_BASE);
  assign seq_clear  = (state == S_CLEAR);

  // saturating base count, as it stands after this base
  assign seen_inc = (&seen) ? seen : seen + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || seq_clear) begin
      seen <= '0;
    end else if (base_acc) begin
      seen <= seen_inc;
    end
  end

  // newest base at the top, oldest at index 0
  always_ff @(posedge clk) begin
    if (rst || seq_clear) begin
      for (int j = 0; j < MAX_LEN; j++) begin
        hist[j] <= '0;
      end
    end else if (base_acc) begin
      for (int j = 0; j < MAX_LEN - 1; j++) begin
        hist[j] <= hist[j+1];
      end
      hist[MAX_LEN-1] <= item.base_code;
    end
  end

  // ---------------------------------------------------------------- column cells
  // cell j holds matrix column j; after alignment its forward base is the window
  // base for column j, and its reverse base the one that column j meets on the
  // reverse strand. partial sums ripple from cell 0 towards the last cell.
  assign wr_value = WEIGHT_BITS'(32'(item.weight_value));

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic signed [SUM_BITS-1:0] f_in, r_in;
    logic [2:0] sh_in;

    if (j == 0) begin : g_first
      assign f_in = '0;
      assign r_in = '0;
    end else begin : g_chain
      assign f_in = fwd_sum[j-1];
      assign r_in = rev_sum[j-1];
    end

    if (j == MAX_LEN - 1) begin : g_end
      assign sh_in = '0;
    end else begin : g_shift
      assign sh_in = fb[j+1];
    end

    assign wr_en[j] = item_acc && (item.op == wmss_pkg::OP_LOAD)
                      && (32'(item.weight_row) == j);
    assign act[j]   = LEN_W'(j) < eff_len;

    wmss_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_BITS    (SUM_BITS)
    ) u_cell (
      .clk          (clk),
      .wr_en        (wr_en[j]),
      .wr_base      (item.weight_base),
      .wr_value     (wr_value),
      .ctrl         (cell_ctrl),
      .active       (act[j]),
      .fwd_load     (hist[j]),
      .rev_load     (hist[MAX_LEN-1-j]),
      .fwd_shift_in (sh_in),
      .fwd_base     (fb[j]),
      .fwd_sum_in   (f_in),
      .rev_sum_in   (r_in),
      .fwd_sum      (fwd_sum[j]),
      .rev_sum      (rev_sum[j])
    );
  end

  // saturate to the 24-bit score range
  assign fwd_wide = CMP_W'(fwd_sum[MAX_LEN-1]);
  assign rev_wide = CMP_W'(rev_sum[MAX_LEN-1]);

  always_comb begin
    if (fwd_wide > CMP_W'(wmss_pkg::SCORE_MAX)) begin
      fwd_score = wmss_pkg::SCORE_MAX;
    end else if (fwd_wide < CMP_W'(wmss_pkg::SCORE_MIN)) begin
      fwd_score = wmss_pkg::SCORE_MIN;
    end else begin
      fwd_score = 24'(fwd_wide);
    end
    if (rev_wide > CMP_W'(wmss_pkg::SCORE_MAX)) begin
      rev_score = wmss_pkg::SCORE_MAX;
    end else if (rev_wide < CMP_W'(wmss_pkg::SCORE_MIN)) begin
      rev_score = wmss_pkg::SCORE_MIN;
    end else begin
      rev_score = 24'(rev_wide);
    end
  end

  assign fwd_hit = fwd_score >= score_cutoff;
  assign rev_hit = scan_reverse && (rev_score >= score_cutoff);

  // window start, saturated to the position width and cut to the field
  assign pos_full = seen - wmss_pkg::SEEN_W'(eff_len);
  assign pos_sat  = (33'(pos_full) > POS_MAX) ? POS_MAX : 33'(pos_full);
  assign pos      = pos_sat[19:0];

  // ---------------------------------------------------------------- best-hit list
  always_comb begin
    list_new.position = pos;
    if (state == S_INS_R) begin
      list_new.score  = rev_score;
      list_new.strand = 1'b1;
    end else begin
      list_new.score  = fwd_score;
      list_new.strand = 1'b0;
    end
  end

  wmss_list #(
    .TOP_N (TOP_N),
    .CAP_W (CAP_W)
  ) u_list (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (list_ctrl),
    .cap         (cap),
    .new_entry   (list_new),
    .head        (list_head),
    .head_filled (head_filled),
    .next_filled (next_filled)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next       = state;
    count_next       = count;
    drain_next       = drain;
    emit             = 1'b0;
    res_next         = '0;
    cell_ctrl        = '0;
    list_ctrl        = '0;
    list_ctrl.clear  = seq_clear;

    unique case (state)
      S_IDLE: begin
        if (item_acc) begin
          unique case (item.op)
            wmss_pkg::OP_BASE: begin
              // nothing to score until the window is full
              if (seen_inc >= wmss_pkg::SEEN_W'(eff_len)) begin
                state_next = S_LOAD;
              end
            end
            wmss_pkg::OP_END: begin
              if (!return_all_scores && (cap != '0)) begin
                drain_next = cap;
                state_next = S_DRAIN;
              end else begin
                state_next = S_CLEAR;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cell_ctrl.load = 1'b1;
        count_next     = LEN_W'(MAX_LEN) - eff_len;
        state_next     = S_ALIGN;
      end
      S_ALIGN: begin
        if (count != '0) begin
          cell_ctrl.shift = 1'b1;
          count_next      = count - 1'b1;
        end else begin
          count_next = LEN_W'(MAX_LEN - 1);
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        // wait for the sums to ripple through the whole row
        if (count == '0) begin
          state_next = S_DECIDE;
        end else begin
          count_next = count - 1'b1;
        end
      end
      S_DECIDE: begin
        if (return_all_scores) begin
          if (out_free) begin
            emit                  = 1'b1;
            res_next.hit_score    = fwd_score;
            res_next.hit_position = pos;
            res_next.last_result  = 1'b1;
            state_next            = S_IDLE;
          end
        end else if (cap == '0) begin
          state_next = S_EMIT_F;
        end else begin
          list_ctrl.insert = fwd_hit;
          state_next       = S_INS_R;
        end
      end
      S_EMIT_F: begin
        if (!fwd_hit) begin
          state_next = S_EMIT_R;
        end else if (out_free) begin
          emit                  = 1'b1;
          res_next.hit_score    = fwd_score;
          res_next.hit_position = pos;
          res_next.last_result  = !rev_hit;
          state_next            = rev_hit ? S_EMIT_R : S_IDLE;
        end
      end
      S_EMIT_R: begin
        if (!rev_hit) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit                  = 1'b1;
          res_next.hit_score    = rev_score;
          res_next.hit_position = pos;
          res_next.hit_strand   = 1'b1;
          res_next.last_result  = 1'b1;
          state_next            = S_IDLE;
        end
      end
      S_INS_R: begin
        list_ctrl.insert = rev_hit;
        state_next       = S_IDLE;
      end
      S_DRAIN: begin
        // the list pops from its head, best entry first
        if (!head_filled || (drain == '0)) begin
          state_next = S_CLEAR;
        end else if (out_free) begin
          emit                  = 1'b1;
          res_next.hit_score    = list_head.score;
          res_next.hit_position = list_head.position;
          res_next.hit_strand   = list_head.strand;
          res_next.last_result  = (drain == CAP_W'(1)) || !next_filled;
          list_ctrl.pop         = 1'b1;
          drain_next            = drain - 1'b1;
          if (res_next.last_result) begin
            state_next = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      drain <= drain_next;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

endmodule

FILE: rtl/core/wmss_checker.sv
module wmss_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input wmss_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input wmss_pkg::result_t result
);

  // a stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // a weight load never blocks the next item
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.op == wmss_pkg::OP_LOAD) |=> !item_stall)
    else $error("weight load held the input");

  // an unused opcode never blocks the next item either
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.op != wmss_pkg::OP_LOAD)
    && (item.op != wmss_pkg::OP_BASE) && (item.op != wmss_pkg::OP_END) |=> !item_stall)
    else $error("unused opcode held the input");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

endmodule

bind weight_matrix_sequence_scan wmss_checker u_wmss_checker (.*);

FILE: verif/weight_matrix_sequence_scan_tb.sv
module weight_matrix_sequence_scan_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WIN_LEN = 32;
  localparam int LIST_LEN = 16;
  localparam int POS_MAX = (1 << 20) - 1;
  localparam int SEEN_SAT = (1 << 21) - 1;
  localparam int SENTINEL = -25600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  wmss_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  wmss_pkg::result_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  weight_matrix_sequence_scan i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // items waiting to be offered, and hits the scanner still owes us
  wmss_pkg::item_t   stim_q[$];
  wmss_pkg::result_t hit_q[$];
  int                fail_cnt = 0;

  // idling controls, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  // shadow copy of the scanner state
  logic signed [15:0] pwm [WIN_LEN][4];
  logic [2:0] seq_win [WIN_LEN];
  int         seen_cnt;
  int         top_score [LIST_LEN];
  int         top_pos [LIST_LEN];
  bit         top_strand [LIST_LEN];
  bit         top_valid [LIST_LEN];

  // shadow registers
  logic [5:0]         cfg_len;
  logic signed [23:0] cfg_cutoff;
  logic [4:0]         cfg_count;
  bit                 cfg_rev;
  bit                 cfg_all;

  function automatic void clear_seq();
    for (int i = 0; i < WIN_LEN; i++) seq_win[i] = '0;
    seen_cnt = 0;
    for (int i = 0; i < LIST_LEN; i++) begin
      top_score[i] = SENTINEL;
      top_pos[i] = 0;
      top_strand[i] = 1'b0;
      top_valid[i] = 1'b0;
    end
  endfunction

  function automatic int column_min(int col);
    int m;
    m = int'(pwm[col][0]);
    for (int c = 1; c < 4; c++) if (int'(pwm[col][c]) < m) m = int'(pwm[col][c]);
    return m;
  endfunction

  function automatic int clip24(int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic bit beats(int s, bit st, int p, int k);
    if (s != top_score[k]) return s > top_score[k];
    if (st != top_strand[k]) return st < top_strand[k];
    return p < top_pos[k];
  endfunction

  function automatic void rank_insert(int s, bit st, int p, int cap);
    int k;
    k = 0;
    while (k < cap && top_valid[k] && !beats(s, st, p, k)) k++;
    if (k >= cap) return;
    for (int q = cap - 1; q > k; q--) begin
      top_score[q] = top_score[q-1];
      top_pos[q] = top_pos[q-1];
      top_strand[q] = top_strand[q-1];
      top_valid[q] = top_valid[q-1];
    end
    top_score[k] = s;
    top_pos[k] = p;
    top_strand[k] = st;
    top_valid[k] = 1'b1;
  endfunction

  function automatic wmss_pkg::result_t make_hit(int s, int p, bit st);
    wmss_pkg::result_t r;
    r.hit_score = s[23:0];
    r.hit_position = p[19:0];
    r.hit_strand = st;
    r.last_result = 1'b0;
    return r;
  endfunction

  // work out the hits one accepted item causes
  function automatic void score_item(wmss_pkg::item_t it);
    wmss_pkg::result_t hits[$];
    int len, cap, fs, rs, pos, b, rc;
    len = (cfg_len < 1) ? 1 : (cfg_len > WIN_LEN) ? WIN_LEN : int'(cfg_len);
    cap = (cfg_count > LIST_LEN) ? LIST_LEN : int'(cfg_count);
    if (it.op == wmss_pkg::OP_LOAD) begin
      pwm[it.weight_row][it.weight_base] = it.weight_value;
    end else if (it.op == wmss_pkg::OP_BASE) begin
      for (int i = 0; i < WIN_LEN - 1; i++) seq_win[i] = seq_win[i+1];
      seq_win[WIN_LEN-1] = it.base_code;
      if (seen_cnt < SEEN_SAT) seen_cnt++;
      if (seen_cnt >= len) begin
        fs = 0;
        rs = 0;
        for (int i = 0; i < len; i++) begin
          b = int'(seq_win[WIN_LEN - len + i]);
          rc = len - 1 - i;
          if (b < 4) begin
            fs += int'(pwm[i][b]);
            rs += int'(pwm[rc][3-b]);
          end else if (b == int'(wmss_pkg::BASE_N)) begin
            fs += column_min(i);
            rs += column_min(rc);
          end
        end
        fs = clip24(fs);
        rs = clip24(rs);
        pos = seen_cnt - len;
        if (pos > POS_MAX) pos = POS_MAX;
        if (cfg_all) hits.push_back(make_hit(fs, pos, 1'b0));
        else if (cap == 0) begin
          if (fs >= cfg_cutoff) hits.push_back(make_hit(fs, pos, 1'b0));
          if (cfg_rev && rs >= cfg_cutoff) hits.push_back(make_hit(rs, pos, 1'b1));
        end else begin
          if (fs >= cfg_cutoff) rank_insert(fs, 1'b0, pos, cap);
          if (cfg_rev && rs >= cfg_cutoff) rank_insert(rs, 1'b1, pos, cap);
        end
      end
    end else if (it.op == wmss_pkg::OP_END) begin
      if (!cfg_all)
        for (int k = 0; k < cap; k++)
          if (top_valid[k])
            hits.push_back(make_hit(top_score[k], top_pos[k], top_strand[k]));
      clear_seq();
    end
    if (hits.size() > 0) hits[hits.size()-1].last_result = 1'b1;
    foreach (hits[i]) hit_q.push_back(hits[i]);
  endfunction

  // driver: offers pending items, holds a stalled item steady
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) score_item(item);
      if (!item_valid || !item_stall) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= stim_q.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off when requested, once a result is waiting
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else if (hold_req && result_valid) begin
      hold_req = 1'b0;
      hold_cnt <= 400;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: each accepted hit against the oldest one owed
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (hit_q.size() == 0) begin
        $error("unexpected hit score %0d pos %0d", result.hit_score, result.hit_position);
        fail_cnt++;
      end else begin
        wmss_pkg::result_t want;
        want = hit_q.pop_front();
        if (result.hit_score !== want.hit_score) begin
          $error("hit_score expected %0d actual %0d", want.hit_score, result.hit_score);
          fail_cnt++;
        end
        if (result.hit_position !== want.hit_position) begin
          $error("hit_position expected %0d actual %0d", want.hit_position,
                 result.hit_position);
          fail_cnt++;
        end
        if (result.hit_strand !== want.hit_strand) begin
          $error("hit_strand expected %0d actual %0d", want.hit_strand, result.hit_strand);
          fail_cnt++;
        end
        if (result.last_result !== want.last_result) begin
          $error("last_result expected %0d actual %0d", want.last_result,
                 result.last_result);
          fail_cnt++;
        end
      end
    end
  end

  // apb write, setup then access
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wmss_pkg::REG_MOTIF_LENGTH:      cfg_len = val[5:0];
      wmss_pkg::REG_SCORE_CUTOFF:      cfg_cutoff = val[23:0];
      wmss_pkg::REG_REPORT_COUNT:      cfg_count = val[4:0];
      wmss_pkg::REG_SCAN_REVERSE:      cfg_rev = val[0];
      wmss_pkg::REG_RETURN_ALL_SCORES: cfg_all = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(int len, int cutoff, int cnt, bit rev, bit all);
    reg_write(wmss_pkg::REG_MOTIF_LENGTH, len);
    reg_write(wmss_pkg::REG_SCORE_CUTOFF, cutoff);
    reg_write(wmss_pkg::REG_REPORT_COUNT, cnt);
    reg_write(wmss_pkg::REG_SCAN_REVERSE, 32'(rev));
    reg_write(wmss_pkg::REG_RETURN_ALL_SCORES, 32'(all));
  endtask

  // wait until no item is queued or offered and no hit is owed, long enough to cover a window still being scored
  task automatic wait_quiet();
    int calm;
    calm = 0;
    while (calm < 100) begin
      @(posedge clk);
      if (stim_q.size() == 0 && !item_valid && hit_q.size() == 0) calm++;
      else calm = 0;
    end
  endtask

  task automatic push_item(logic [1:0] op, int row, int b, int val, int code);
    wmss_pkg::item_t it;
    logic [31:0] rnd;
    rnd = $urandom;
    it = rnd[$bits(wmss_pkg::item_t)-1:0];
    it.op = op;
    if (op == wmss_pkg::OP_LOAD) begin
      it.weight_row = row[4:0];
      it.weight_base = b[1:0];
      it.weight_value = val[15:0];
    end
    if (op == wmss_pkg::OP_BASE) it.base_code = code[2:0];
    stim_q.push_back(it);
  endtask

  // mostly bases with acgt bias, some reloads, ends and unused ops
  task automatic push_random(int count, int end_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < end_pct) push_item(wmss_pkg::OP_END, 0, 0, 0, 0);
      else if (r < end_pct + 5)
        push_item(wmss_pkg::OP_LOAD, $urandom_range(31), $urandom_range(3),
                  $urandom_range(65535), 0);
      else if (r < end_pct + 6) push_item(OP_UNUSED, 0, 0, 0, 0);
      else if ($urandom_range(9) < 8) push_item(wmss_pkg::OP_BASE, 0, 0, 0, $urandom_range(3));
      else push_item(wmss_pkg::OP_BASE, 0, 0, 0, $urandom_range(7, 4));
    end
    push_item(wmss_pkg::OP_END, 0, 0, 0, 0);
  endtask

  initial begin
    for (int c = 0; c < WIN_LEN; c++) for (int b = 0; b < 4; b++) pwm[c][b] = '0;
    clear_seq();
    cfg_len = 6'd1;
    cfg_cutoff = '0;
    cfg_count = '0;
    cfg_rev = 1'b0;
    cfg_all = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // whole matrix loaded first so no unwritten weight is ever read
    for (int c = 0; c < WIN_LEN; c++)
      for (int b = 0; b < 4; b++)
        push_item(wmss_pkg::OP_LOAD, c, b, $urandom_range(65535), 0);
    // directed: weight extremes, every base code, unused op, end
    push_item(wmss_pkg::OP_LOAD, 0, wmss_pkg::BASE_A, 32767, 0);
    push_item(wmss_pkg::OP_LOAD, 0, wmss_pkg::BASE_C, -32768, 0);
    push_item(wmss_pkg::OP_LOAD, 0, wmss_pkg::BASE_G, 0, 0);
    push_item(wmss_pkg::OP_LOAD, 0, wmss_pkg::BASE_T, -1, 0);
    for (int k = 0; k < 8; k++) push_item(wmss_pkg::OP_BASE, 0, 0, 0, k);
    push_item(OP_UNUSED, 0, 0, 0, 0);
    push_item(wmss_pkg::OP_END, 0, 0, 0, 0);
    wait_quiet();

    // streaming both strands, sender idling
    set_all(8, 0, 0, 1'b1, 1'b0);
    send_idle_pct = 60;
    push_random(50, 1);
    wait_quiet();

    // full-length window, full best list, receiver stalling
    set_all(32, -20000, 16, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 60;
    push_random(50, 3);
    wait_quiet();

    // every forward score, zero length acts as one, both idling
    set_all(0, 8388607, 3, 1'b1, 1'b1);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    push_random(45, 2);
    wait_quiet();

    // oversized length and count, lowest cutoff, long receiver hold-off
    set_all(40, -8388608, 20, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random(40, 0);
    hold_req = 1'b1;
    push_random(30, 2);
    wait_quiet();

    // streaming forward only with highest cutoff, then short list
    set_all(5, 8388607, 0, 1'b0, 1'b0);
    push_random(20, 2);
    wait_quiet();
    set_all(3, 1000, 5, 1'b1, 1'b0);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    push_random(40, 4);
    wait_quiet();

    if (fail_cnt == 0 && hit_q.size() == 0) begin
      $display("[weight_matrix_sequence_scan] OK");
    end else begin
      $display("[weight_matrix_sequence_scan] ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[weight_matrix_sequence_scan] ERROR");
    $finish;
  end

endmodule
